>>> design/orr_pkg.sv
package orr_pkg;

   // widths of the score field, the read index, the held count and the divide step
   localparam int unsigned SCORE_W = 10;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned HELD_W  = 7;
   localparam int unsigned STEP_W  = $clog2(SCORE_W);

   // operation codes on req_op
   typedef enum logic [2:0] {
      OP_STORE   = 3'd0,
      OP_LATEST  = 3'd1,
      OP_INDEX   = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_SUMMARY = 3'd4
   } op_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   // one ring entry
   typedef struct packed {
      logic [31:0]        timestamp;
      logic [SCORE_W-1:0] score;
      logic               anomaly;
      logic [15:0]        co;
      logic [15:0]        co2;
      logic [15:0]        nox;
      logic [15:0]        pm25;
      logic signed [11:0] temperature;
      logic [9:0]         humidity;
      logic [13:0]        rpm;
   } rec_type;

endpackage

>>> design/overwriting_reading_ring_core.sv
// Overwriting ring of sensor readings.
// Input channel req_*: one transaction per operation, taken when req_valid is
// high and req_stall low. req_op selects store, read latest, read by index,
// clear or summarize; the reading fields matter for store only.
// Result channel rsp_*: one transaction for read latest, read by index and
// summarize, none for store, clear and unknown codes. rsp_hit low marks a
// zero record (empty ring or index at or beyond the held count).
// Store and clear keep the controller idle and the next transaction may
// follow at once. Reads issue the single memory read on the accepting edge
// and load the output register in the response state once it is free.
// Summarize reads one entry per cycle over the held count N through the one
// read port, then runs a 10-step restoring divide for the mean score.
// The output register decouples the sides: a new transaction is taken while
// a result waits; a later result holds in its final state until the output
// register is free. A stalled result stays unchanged.
// Reset clears the write pointer, the held count and the controller; the
// reading memory is not cleared, since entries are only used once written.
module overwriting_reading_ring_core
   import orr_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic [IDX_W-1:0]    req_index,
   input  logic [31:0]         req_timestamp,
   input  logic [SCORE_W-1:0]  req_emission_score,
   input  logic                req_anomaly,
   input  logic [15:0]         req_co_level,
   input  logic [15:0]         req_co2_level,
   input  logic [15:0]         req_nox_level,
   input  logic [15:0]         req_pm25_level,
   input  logic signed [11:0]  req_temperature,
   input  logic [9:0]          req_humidity,
   input  logic [13:0]         req_engine_rpm,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [31:0]         rsp_out_timestamp,
   output logic [SCORE_W-1:0]  rsp_out_score,
   output logic                rsp_out_anomaly,
   output logic [15:0]         rsp_out_co,
   output logic [15:0]         rsp_out_co2,
   output logic [15:0]         rsp_out_nox,
   output logic [15:0]         rsp_out_pm25,
   output logic signed [11:0]  rsp_out_temperature,
   output logic [9:0]          rsp_out_humidity,
   output logic [13:0]         rsp_out_rpm,
   output logic [HELD_W-1:0]   rsp_held_count
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + SCORE_W;
   localparam int unsigned EXT_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

   // registers
   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [CNT_W-1:0]   fc_ff, fc_in;
   logic [PTR_W-1:0]   walk_addr_ff, walk_addr_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [15:0]        co_max_ff, co_max_in;
   logic [15:0]        pm_max_ff, pm_max_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [SCORE_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               hit_ff, hit_in;
   logic               summary_ff, summary_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [HELD_W-1:0]  rsp_count_ff, rsp_count_in;
   rec_type            rsp_rec_ff, rsp_rec_in;
   rec_type            rd_data_ff;

   // memory and its port controls
   rec_type            mem [DEPTH];
   logic               mem_wr;
   logic               mem_rd;
   logic [PTR_W-1:0]   rd_addr;
   rec_type            wr_rec;

   // address arithmetic
   logic [EXT_W-1:0]   oldest_ext;
   logic [PTR_W-1:0]   oldest_slot;
   logic [EXT_W-1:0]   index_ext;
   logic [PTR_W-1:0]   index_slot;
   logic [PTR_W-1:0]   latest_slot;
   logic               index_hit;

   // walk and divide datapath
   logic [SUM_W-1:0]   acc_sum;
   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     divisor;
   logic               trial_ge;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   assign req_stall = (state_ff != ST_IDLE);

   // record to store
   always_comb begin
      wr_rec.timestamp   = req_timestamp;
      wr_rec.score       = req_emission_score;
      wr_rec.anomaly     = req_anomaly;
      wr_rec.co          = req_co_level;
      wr_rec.co2         = req_co2_level;
      wr_rec.nox         = req_nox_level;
      wr_rec.pm25        = req_pm25_level;
      wr_rec.temperature = req_temperature;
      wr_rec.humidity    = req_humidity;
      wr_rec.rpm         = req_engine_rpm;
   end

   // slots of the oldest, the indexed and the newest reading
   always_comb begin
      oldest_ext = EXT_W'(wp_ff) + DEPTH_EXT - EXT_W'(fc_ff);
      if (oldest_ext >= DEPTH_EXT) begin
         oldest_ext = oldest_ext - DEPTH_EXT;
      end
      oldest_slot = PTR_W'(oldest_ext);
      index_ext = EXT_W'(oldest_slot) + EXT_W'(req_index);
      if (index_ext >= DEPTH_EXT) begin
         index_ext = index_ext - DEPTH_EXT;
      end
      index_slot  = PTR_W'(index_ext);
      index_hit   = EXT_W'(req_index) < EXT_W'(fc_ff);
      latest_slot = (wp_ff == '0) ? PTR_LAST : wp_ff - PTR_W'(1);
   end

   // accumulate and divide step
   always_comb begin
      acc_sum  = sum_ff + SUM_W'(rd_data_ff.score);
      trial    = {rem_ff, quo_ff[SCORE_W-1]};
      divisor  = {1'b0, fc_ff};
      trial_ge = trial >= divisor;
   end

   // controller
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fc_in        = fc_ff;
      walk_addr_in = walk_addr_ff;
      left_in      = left_ff;
      sum_in       = sum_ff;
      co_max_in    = co_max_ff;
      pm_max_in    = pm_max_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      summary_in   = summary_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rec_in   = rsp_rec_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      rd_addr      = walk_addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_STORE: begin
                     mem_wr = 1'b1;
                     wp_in  = ptr_inc(wp_ff);
                     if (fc_ff != CNT_FULL) begin
                        fc_in = fc_ff + CNT_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     wp_in = '0;
                     fc_in = '0;
                  end
                  OP_LATEST: begin
                     mem_rd     = 1'b1;
                     rd_addr    = latest_slot;
                     hit_in     = (fc_ff != '0);
                     summary_in = 1'b0;
                     state_in   = ST_RESP;
                  end
                  OP_INDEX: begin
                     mem_rd     = 1'b1;
                     rd_addr    = index_slot;
                     hit_in     = index_hit;
                     summary_in = 1'b0;
                     state_in   = ST_RESP;
                  end
                  OP_SUMMARY: begin
                     summary_in = 1'b1;
                     hit_in     = (fc_ff != '0);
                     sum_in     = '0;
                     co_max_in  = '0;
                     pm_max_in  = '0;
                     if (fc_ff != '0) begin
                        mem_rd       = 1'b1;
                        rd_addr      = oldest_slot;
                        walk_addr_in = ptr_inc(oldest_slot);
                        left_in      = fc_ff - CNT_W'(1);
                        state_in     = ST_WALK;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            sum_in = acc_sum;
            if (rd_data_ff.co > co_max_ff) begin
               co_max_in = rd_data_ff.co;
            end
            if (rd_data_ff.pm25 > pm_max_ff) begin
               pm_max_in = rd_data_ff.pm25;
            end
            if (left_ff != '0) begin
               mem_rd       = 1'b1;
               rd_addr      = walk_addr_ff;
               walk_addr_in = ptr_inc(walk_addr_ff);
               left_in      = left_ff - CNT_W'(1);
            end else begin
               // sum < count * 1024, so the upper part is below the count
               rem_in   = acc_sum[SUM_W-1:SCORE_W];
               quo_in   = acc_sum[SCORE_W-1:0];
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = trial_ge ? CNT_W'(trial - divisor) : CNT_W'(trial);
            quo_in  = {quo_ff[SCORE_W-2:0], trial_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SCORE_W - 1)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_count_in = HELD_W'(fc_ff);
               rsp_rec_in   = '0;
               if (summary_ff) begin
                  if (hit_ff) begin
                     rsp_rec_in.score = quo_ff;
                     rsp_rec_in.co    = co_max_ff;
                     rsp_rec_in.pm25  = pm_max_ff;
                  end
               end else if (hit_ff) begin
                  rsp_rec_in = rd_data_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // reading memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wp_ff] <= wr_rec;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      walk_addr_ff <= walk_addr_in;
      left_ff      <= left_in;
      sum_ff       <= sum_in;
      co_max_ff    <= co_max_in;
      pm_max_ff    <= pm_max_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      hit_ff       <= hit_in;
      summary_ff   <= summary_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   // result outputs
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_out_timestamp   = rsp_rec_ff.timestamp;
   assign rsp_out_score       = rsp_rec_ff.score;
   assign rsp_out_anomaly     = rsp_rec_ff.anomaly;
   assign rsp_out_co          = rsp_rec_ff.co;
   assign rsp_out_co2         = rsp_rec_ff.co2;
   assign rsp_out_nox         = rsp_rec_ff.nox;
   assign rsp_out_pm25        = rsp_rec_ff.pm25;
   assign rsp_out_temperature = rsp_rec_ff.temperature;
   assign rsp_out_humidity    = rsp_rec_ff.humidity;
   assign rsp_out_rpm         = rsp_rec_ff.rpm;
   assign rsp_held_count      = rsp_count_ff;

`ifndef SYNTHESIS
   // held count saturates at the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= CNT_FULL)
      else $error("held count beyond depth");

   // write pointer stays inside the ring
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_LAST)
      else $error("write pointer beyond depth");

   // ring state frozen while an operation is in progress
   a_busy_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> ($stable(fc_ff) && $stable(wp_ff)))
      else $error("ring state changed while busy");

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < fc_ff))
      else $error("divider remainder out of range");
`endif

endmodule
